/* rtl/kdps_pkg.sv */
// ----------------------------------------------------------------------------
// kdps_pkg
// shared constants, codes and controller/datapath types of the keyed dirty
// point store
// ----------------------------------------------------------------------------
package kdps_pkg;

  localparam int MAX_POINTS      = 16;
  localparam int BUFFER_BYTES    = 256;
  localparam int MAX_POINT_BYTES = 8;

  localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int BUF_AW  = $clog2(BUFFER_BYTES);
  localparam int BUF_CW  = $clog2(BUFFER_BYTES + 1);
  localparam int BLANE_W = (MAX_POINT_BYTES > 1) ? $clog2(MAX_POINT_BYTES) : 1;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int SIZE_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;

  localparam logic [KEY_W-1:0] NO_KEY = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_DEFINE      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET         = 3'd1;
  localparam logic [OP_W-1:0] OP_GET         = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ONE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd4;
  localparam logic [OP_W-1:0] OP_FIRST_DIRTY = 3'd5;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PROBE,
    ST_COMPARE,
    ST_XFER,
    ST_SCAN,
    ST_SCAN_KEY,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_MISS,
    RES_REFUSED,
    RES_GET,
    RES_DIRTY
  } res_code_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [BUF_AW-1:0] off;
  } entry_t;

  typedef struct packed {
    logic      load_item;
    logic      search_init;
    logic      probe;
    logic      compare_step;
    logic      xfer_init;
    logic      xfer_step;
    logic      define_pt;
    logic      set_dirty;
    logic      clr_dirty;
    logic      clr_all;
    logic      scan_init;
    logic      scan_step;
    logic      scan_read;
    logic      res_load;
    res_code_t res_code;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            define_ok;
    logic            search_open;
    logic            key_eq;
    logic            xfer_done;
    logic            scan_end;
    logic            scan_hit;
    logic            out_free;
  } sts_t;

endpackage

/* rtl/kdps_ctrl.sv */
// ----------------------------------------------------------------------------
// kdps_ctrl
// sequencer of the point store: steps each item through define, binary
// search, byte transfer, dirty scan and result hand-off
// ----------------------------------------------------------------------------
module kdps_ctrl import kdps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts.op) inside
          OP_DEFINE:                    state_next = ST_RESULT;
          OP_SET, OP_GET, OP_CLEAR_ONE: state_next = ST_PROBE;
          OP_FIRST_DIRTY:               state_next = ST_SCAN;
          default:                      state_next = ST_RESULT;
        endcase
      end
      ST_PROBE: begin
        state_next = sts.search_open ? ST_COMPARE : ST_RESULT;
      end
      ST_COMPARE: begin
        if (sts.key_eq) begin
          state_next = (sts.op == OP_CLEAR_ONE) ? ST_RESULT : ST_XFER;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_XFER: begin
        if (sts.xfer_done) state_next = ST_RESULT;
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_next = ST_RESULT;
        end else if (sts.scan_hit) begin
          state_next = ST_SCAN_KEY;
        end
      end
      ST_SCAN_KEY: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_code = RES_OK;
    unique case (state)
      ST_IDLE: begin
        cmd.load_item = in_valid;
      end
      ST_DISPATCH: begin
        unique case (sts.op) inside
          OP_DEFINE: begin
            cmd.define_pt = sts.define_ok;
            cmd.res_load  = 1'b1;
            cmd.res_code  = sts.define_ok ? RES_OK : RES_REFUSED;
          end
          OP_SET, OP_GET, OP_CLEAR_ONE: begin
            cmd.search_init = 1'b1;
          end
          OP_CLEAR_ALL: begin
            cmd.clr_all  = 1'b1;
            cmd.res_load = 1'b1;
          end
          OP_FIRST_DIRTY: begin
            cmd.scan_init = 1'b1;
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
      end
      ST_PROBE: begin
        if (sts.search_open) begin
          cmd.probe = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_MISS;
        end
      end
      ST_COMPARE: begin
        cmd.compare_step = 1'b1;
        if (sts.key_eq) begin
          if (sts.op == OP_CLEAR_ONE) begin
            cmd.clr_dirty = 1'b1;
            cmd.res_load  = 1'b1;
          end else begin
            cmd.xfer_init = 1'b1;
          end
        end
      end
      ST_XFER: begin
        cmd.xfer_step = 1'b1;
        if (sts.xfer_done) begin
          cmd.res_load  = 1'b1;
          cmd.res_code  = (sts.op == OP_GET) ? RES_GET : RES_OK;
          cmd.set_dirty = (sts.op == OP_SET);
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_MISS;
        end else if (sts.scan_hit) begin
          cmd.scan_read = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SCAN_KEY: begin
        cmd.res_load = 1'b1;
        cmd.res_code = RES_DIRTY;
      end
      ST_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/kdps_dpath.sv */
// ----------------------------------------------------------------------------
// kdps_dpath
// point table, dirty marks, byte buffer, search and scan registers, result
// and output registers of the point store
// ----------------------------------------------------------------------------
module kdps_dpath import kdps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  input  logic [SIZE_W-1:0]   byte_count,
  input  logic [VALUE_W-1:0]  value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    buffer_bytes_in_use,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  read_value,
  output logic [SIZE_W-1:0]   read_size,
  output logic [KEY_W-1:0]    dirty_key
);

  // item registers
  logic [OP_W-1:0]    item_op;
  logic [KEY_W-1:0]   item_key;
  logic [SIZE_W-1:0]  item_count;
  logic [VALUE_W-1:0] item_value;

  // table state
  logic [CFG_W-1:0]      bytes_in_use;
  logic [CNT_W-1:0]      pt_count;
  logic [BUF_CW-1:0]     free_off;
  logic [KEY_W-1:0]      last_key;
  logic [MAX_POINTS-1:0] dirty;
  entry_t                ent_mem [MAX_POINTS];
  entry_t                ent_rd;

  // search, scan and transfer
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   slot;
  logic [SIZE_W-1:0]  ent_size;
  logic [BUF_AW-1:0]  ent_off;
  logic [SIZE_W-1:0]  xi;
  logic [VALUE_W-1:0] acc;

  // byte buffer
  logic [7:0]              byte_mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] byte_vld;
  logic [7:0]              rd_byte;
  logic                    rd_vld;

  // result
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [SIZE_W-1:0]   res_size;
  logic [KEY_W-1:0]    res_dkey;
  logic [STATUS_W-1:0] res_status_next;
  logic [VALUE_W-1:0]  res_value_next;
  logic [SIZE_W-1:0]   res_size_next;
  logic [KEY_W-1:0]    res_dkey_next;

  logic [BUF_CW-1:0]  lim;
  logic [BUF_CW-1:0]  remain;
  logic               define_ok;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_calc;
  logic [IDX_W-1:0]   ent_raddr;
  logic               key_eq;
  logic               key_lt;
  logic [BUF_AW:0]    baddr_full;
  logic               addr_ok;
  logic [BUF_AW-1:0]  baddr;
  logic               xfer_act;
  logic               byte_wr;
  logic               byte_rd;
  logic [7:0]         wr_byte;
  logic [SIZE_W-1:0]  prev_xi;
  logic [VALUE_W-1:0] acc_next;
  logic               out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op    <= op;
      item_key   <= key;
      item_count <= byte_count;
      item_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bytes_in_use <= buffer_bytes_in_use;
    end
  end

  // allocation check
  assign lim = (bytes_in_use > CFG_W'(BUFFER_BYTES)) ? BUF_CW'(BUFFER_BYTES)
                                                     : BUF_CW'(bytes_in_use);
  assign remain = (free_off < lim) ? (lim - free_off) : '0;
  assign define_ok = (pt_count < CNT_W'(MAX_POINTS))
                  && ((pt_count == '0) || (item_key > last_key))
                  && (item_key != NO_KEY)
                  && (item_count != '0)
                  && (item_count <= SIZE_W'(MAX_POINT_BYTES))
                  && (BUF_CW'(item_count) <= remain);

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_count <= '0;
      free_off <= '0;
    end else if (cmd.define_pt) begin
      pt_count <= pt_count + CNT_W'(1);
      free_off <= free_off + BUF_CW'(item_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.define_pt) begin
      last_key <= item_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= '0;
    end else if (cmd.clr_all) begin
      dirty <= '0;
    end else if (cmd.define_pt) begin
      dirty[pt_count[IDX_W-1:0]] <= 1'b0;
    end else if (cmd.set_dirty) begin
      dirty[slot[IDX_W-1:0]] <= 1'b1;
    end else if (cmd.clr_dirty) begin
      dirty[mid[IDX_W-1:0]] <= 1'b0;
    end
  end

  // point table, one write and one registered read port
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_calc  = mid_sum[CNT_W:1];
  assign ent_raddr = cmd.scan_read ? slot[IDX_W-1:0] : mid_calc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.define_pt) begin
      ent_mem[pt_count[IDX_W-1:0]] <= '{key: item_key, size: item_count,
                                        off: free_off[BUF_AW-1:0]};
    end
    if (cmd.probe || cmd.scan_read) begin
      ent_rd <= ent_mem[ent_raddr];
    end
  end

  // binary search and scan
  assign key_eq = (item_key == ent_rd.key);
  assign key_lt = (item_key < ent_rd.key);

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo <= '0;
      hi <= pt_count;
    end else if (cmd.compare_step && !key_eq) begin
      if (key_lt) begin
        hi <= mid;
      end else begin
        lo <= mid + CNT_W'(1);
      end
    end
    if (cmd.probe) begin
      mid <= mid_calc;
    end
    if (cmd.compare_step && key_eq) begin
      slot     <= mid;
      ent_size <= ent_rd.size;
      ent_off  <= ent_rd.off;
    end else if (cmd.scan_init) begin
      slot <= '0;
    end else if (cmd.scan_step) begin
      slot <= slot + CNT_W'(1);
    end
  end

  // byte transfer, one byte a cycle
  assign baddr_full = {1'b0, ent_off} + (BUF_AW + 1)'(xi);
  assign addr_ok    = (baddr_full < (BUF_AW + 1)'(BUFFER_BYTES));
  assign baddr      = baddr_full[BUF_AW-1:0];
  assign xfer_act   = cmd.xfer_step && (xi < ent_size);
  assign byte_wr    = xfer_act && (item_op == OP_SET) && addr_ok;
  assign byte_rd    = xfer_act && (item_op == OP_GET);
  assign wr_byte    = item_value[{xi[BLANE_W-1:0], 3'd0} +: 8];
  assign prev_xi    = xi - SIZE_W'(1);

  always_comb begin
    acc_next = acc;
    if (cmd.xfer_step && (xi != '0) && (item_op == OP_GET)) begin
      for (int b = 0; b < MAX_POINT_BYTES; b++) begin
        if (prev_xi[BLANE_W-1:0] == BLANE_W'(b)) begin
          acc_next[8*b +: 8] = rd_vld ? rd_byte : 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xfer_init) begin
      xi  <= '0;
      acc <= '0;
    end else if (cmd.xfer_step) begin
      acc <= acc_next;
      if (xi < ent_size) begin
        xi <= xi + SIZE_W'(1);
      end
    end
  end

  // a byte never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= '0;
    end else if (byte_wr) begin
      byte_vld[baddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_wr) begin
      byte_mem[baddr] <= wr_byte;
    end
    if (byte_rd) begin
      rd_byte <= byte_mem[baddr];
      rd_vld  <= addr_ok && byte_vld[baddr];
    end
  end

  // result and output registers
  always_comb begin
    res_status_next = STS_OK;
    res_value_next  = '0;
    res_size_next   = '0;
    res_dkey_next   = NO_KEY;
    case (cmd.res_code)
      RES_MISS:    res_status_next = STS_MISS;
      RES_REFUSED: res_status_next = STS_REFUSED;
      RES_GET: begin
        res_value_next = acc_next;
        res_size_next  = ent_size;
      end
      RES_DIRTY:   res_dkey_next = ent_rd.key;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
      res_size   <= res_size_next;
      res_dkey   <= res_dkey_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      read_value <= res_value;
      read_size  <= res_size;
      dirty_key  <= res_dkey;
    end
  end

  always_comb begin
    sts             = '0;
    sts.op          = item_op;
    sts.define_ok   = define_ok;
    sts.search_open = (lo < hi);
    sts.key_eq      = key_eq;
    sts.xfer_done   = (xi == ent_size);
    sts.scan_end    = (slot >= pt_count);
    sts.scan_hit    = dirty[slot[IDX_W-1:0]];
    sts.out_free    = out_free;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pt_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table depth");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_off <= BUF_CW'(BUFFER_BYTES))
    else $error("free offset beyond buffer");

  a_dirty_defined: assert property (@(posedge clk) disable iff (rst)
    (dirty >> pt_count) == '0)
    else $error("dirty mark on undefined point");

  a_get_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_size != '0) |->
      (status == STS_OK) && (read_size <= SIZE_W'(MAX_POINT_BYTES)))
    else $error("bad get result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over pending beat");
`endif

endmodule

/* rtl/keyed_dirty_point_store_top.sv */
// ----------------------------------------------------------------------------
// keyed_dirty_point_store_top
// store of up to 16 keyed points of 1 to 8 bytes in a 256-byte buffer, each
// with a dirty mark
// ----------------------------------------------------------------------------
// input beat (in_valid/in_stall): op, key, byte_count, value. one result beat
// (out_valid/out_stall) per input beat: status, read_value, read_size, dirty_key.
// config beat (cfg_valid/cfg_ready): buffer_bytes_in_use, to be written by the
// user only while the store is idle, unchecked by the block; cfg_ready is always high.
// one item is worked at a time; in_stall is high from the accepting edge until
// the result enters the output register. define, clear all and unused ops go
// from dispatch straight to the result. set, get and clear one run a binary
// search of up to 5 probes, each a read of the point table's single registered
// read port and a compare; a set or get that finds its point then moves its
// bytes through the byte buffer's single port, one byte a cycle. first dirty
// scans the points in table order and reads the key of the first dirty one.
// the next item is taken while the previous result still waits in the output
// register; a stalled result holds and a further result waits behind it.
// reset (rst, synchronous) empties the table, clears every dirty mark and
// reads the whole buffer as zero, and sets buffer_bytes_in_use to 256.
// ----------------------------------------------------------------------------
module keyed_dirty_point_store_top import kdps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    key,
  input  logic [SIZE_W-1:0]   byte_count,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  read_value,
  output logic [SIZE_W-1:0]   read_size,
  output logic [KEY_W-1:0]    dirty_key,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    buffer_bytes_in_use
);

  cmd_t cmd;
  sts_t sts;

  kdps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kdps_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .op                  (op),
    .key                 (key),
    .byte_count          (byte_count),
    .value               (value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .buffer_bytes_in_use (buffer_bytes_in_use),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .read_value          (read_value),
    .read_size           (read_size),
    .dirty_key           (dirty_key)
  );

endmodule

/* tb/keyed_dirty_point_store_tb.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// keyed dirty point store testbench
// defines points in rising key order, then sets, reads, marks, clears and scans
// them under random idling and long output back-pressure. a shadow of the point
// table, dirty marks and byte buffer predicts each result beat, which is then
// compared field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
  import kdps_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 6;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [SIZE_W-1:0]   read_size;
    logic [KEY_W-1:0]    dirty_key;
  } reply_t;

  class point_store_sb;
    int unsigned      bytes_in_use;
    logic [KEY_W-1:0] keys [MAX_POINTS];
    int unsigned      sizes [MAX_POINTS];
    int unsigned      offsets [MAX_POINTS];
    bit               dirty [MAX_POINTS];
    int unsigned      count;
    int unsigned      next_off;
    logic [7:0]       bytes_mem [BUFFER_BYTES];
    reply_t           replies_due [$];
    int               errors;

    function new();
      bytes_in_use = CFG_RESET;
      count = 0;
      next_off = 0;
      errors = 0;
      foreach (dirty[i]) dirty[i] = 1'b0;
      foreach (bytes_mem[i]) bytes_mem[i] = 8'h00;
    endfunction

    function void write_limit(logic [CFG_W-1:0] v);
      bytes_in_use = v;
    endfunction

    function int find_point(logic [KEY_W-1:0] k);
      for (int i = 0; i < count; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function logic [STATUS_W-1:0] define_point(logic [KEY_W-1:0] k, logic [SIZE_W-1:0] n);
      int unsigned cap;
      int unsigned room;
      cap = (bytes_in_use > BUFFER_BYTES) ? BUFFER_BYTES : bytes_in_use;
      room = (next_off < cap) ? cap - next_off : 0;
      if (count >= MAX_POINTS) return STS_REFUSED;
      if (count > 0 && k <= keys[count-1]) return STS_REFUSED;
      if (k == NO_KEY || n == 0 || n > MAX_POINT_BYTES || n > room) return STS_REFUSED;
      keys[count] = k;
      sizes[count] = n;
      offsets[count] = next_off;
      dirty[count] = 1'b0;
      count++;
      next_off += n;
      return STS_OK;
    endfunction

    // works out the result beat of one accepted item and queues it
    function void note_request(logic [OP_W-1:0] o, logic [KEY_W-1:0] k,
                               logic [SIZE_W-1:0] n, logic [VALUE_W-1:0] v);
      reply_t r;
      int slot;
      r.status = STS_OK;
      r.read_value = '0;
      r.read_size = '0;
      r.dirty_key = NO_KEY;
      case (o)
        OP_DEFINE: r.status = define_point(k, n);
        OP_SET, OP_GET, OP_CLEAR_ONE: begin
          slot = find_point(k);
          if (slot < 0) begin
            r.status = STS_MISS;
          end else if (o == OP_SET) begin
            for (int i = 0; i < sizes[slot]; i++)
              bytes_mem[offsets[slot] + i] = v[8*i +: 8];
            dirty[slot] = 1'b1;
          end else if (o == OP_GET) begin
            for (int i = 0; i < sizes[slot]; i++)
              r.read_value[8*i +: 8] = bytes_mem[offsets[slot] + i];
            r.read_size = SIZE_W'(sizes[slot]);
          end else begin
            dirty[slot] = 1'b0;
          end
        end
        OP_CLEAR_ALL: foreach (dirty[i]) dirty[i] = 1'b0;
        OP_FIRST_DIRTY: begin
          r.status = STS_MISS;
          for (int i = 0; i < count; i++) begin
            if (dirty[i]) begin
              r.dirty_key = keys[i];
              r.status = STS_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        fail($sformatf("result beat with none due, status %0d", got.status));
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        fail($sformatf("status expected %0d got %0d", want.status, got.status));
      if (got.read_value !== want.read_value)
        fail($sformatf("read_value expected %h got %h", want.read_value, got.read_value));
      if (got.read_size !== want.read_size)
        fail($sformatf("read_size expected %0d got %0d", want.read_size, got.read_size));
      if (got.dirty_key !== want.dirty_key)
        fail($sformatf("dirty_key expected %h got %h", want.dirty_key, got.dirty_key));
    endfunction

    function void close_out();
      if (replies_due.size() != 0)
        fail($sformatf("%0d result beats never arrived", replies_due.size()));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  logic [SIZE_W-1:0]   byte_count;
  logic [VALUE_W-1:0]  value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;
  logic [SIZE_W-1:0]   read_size;
  logic [KEY_W-1:0]    dirty_key;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    buffer_bytes_in_use;

  int unsigned   sender_idle_pct;
  int unsigned   stall_pct;
  bit            hold_go;
  point_store_sb sb = new();

  keyed_dirty_point_store_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .op                  (op),
    .key                 (key),
    .byte_count          (byte_count),
    .value               (value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .read_value          (read_value),
    .read_size           (read_size),
    .dirty_key           (dirty_key),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .buffer_bytes_in_use (buffer_bytes_in_use)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input logic [OP_W-1:0] t_op, input logic [KEY_W-1:0] t_key,
                           input logic [SIZE_W-1:0] t_cnt, input logic [VALUE_W-1:0] t_val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= t_op;
    key        <= t_key;
    byte_count <= t_cnt;
    value      <= t_val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(t_op, t_key, t_cnt, t_val);
  endtask

  task automatic set_buffer_limit(input logic [CFG_W-1:0] v);
    cfg_valid           <= 1'b1;
    buffer_bytes_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_limit(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // next key above the last point, spaced so the table can still reach the top key
  function automatic logic [KEY_W-1:0] fresh_key();
    longint unsigned last;
    longint unsigned span;
    if (sb.count == 0) return KEY_W'($urandom_range(255));
    if (sb.count >= MAX_POINTS - 1) return NO_KEY - 1;
    last = sb.keys[sb.count-1];
    span = (64'hFFFF_FFFE - last) / (MAX_POINTS - sb.count);
    if (span <= 1 || $urandom_range(3) == 0) return KEY_W'(last + 1);
    return KEY_W'(last + 1 + $urandom_range(0, 32'(span - 1)));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    int slot;
    r = $urandom_range(99);
    if (sb.count == 0 || r >= 90) return $urandom;
    slot = $urandom_range(sb.count - 1);
    if (r < 80) return sb.keys[slot];
    return (r < 85) ? sb.keys[slot] + 1 : sb.keys[slot] - 1;
  endfunction

  task automatic random_item();
    int r;
    logic [KEY_W-1:0] k;
    logic [SIZE_W-1:0] n;
    r = $urandom_range(99);
    n = SIZE_W'($urandom_range(15));
    if (r < 4) begin
      send_item(OP_DEFINE, fresh_key(), SIZE_W'($urandom_range(1, MAX_POINT_BYTES)),
                rand_value());
    end else if (r < 9) begin
      // malformed defines: stale key, reserved key, bad size
      case ($urandom_range(3))
        0: k = (sb.count != 0) ? sb.keys[$urandom_range(sb.count - 1)] : '0;
        1: k = NO_KEY;
        default: k = $urandom;
      endcase
      if ($urandom_range(1))
        n = $urandom_range(1) ? 4'd0 : SIZE_W'($urandom_range(MAX_POINT_BYTES + 1, 15));
      send_item(OP_DEFINE, k, n, rand_value());
    end else if (r < 35) begin
      send_item(OP_SET, pick_key(), n, rand_value());
    end else if (r < 62) begin
      send_item(OP_GET, pick_key(), n, rand_value());
    end else if (r < 72) begin
      send_item(OP_CLEAR_ONE, pick_key(), n, rand_value());
    end else if (r < 80) begin
      send_item(OP_CLEAR_ALL, $urandom, n, rand_value());
    end else if (r < 94) begin
      send_item(OP_FIRST_DIRTY, $urandom, n, rand_value());
    end else begin
      send_item($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, $urandom, n, rand_value());
    end
  endtask

  // result side: checks accepted beats and drives the stall pattern
  initial begin
    int hold_left;
    reply_t got;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.status = status;
        got.read_value = read_value;
        got.read_size = read_size;
        got.dirty_key = dirty_key;
        sb.check_reply(got);
      end
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int cfg_v;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_DEFINE;
    key = '0;
    byte_count = '0;
    value = '0;
    cfg_valid = 1'b0;
    buffer_bytes_in_use = CFG_RESET;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // one-byte buffer: refusals, a single point, dirty handling
    set_buffer_limit(9'd1);
    send_item(OP_DEFINE, 32'd0, 4'd2, '0);
    send_item(OP_DEFINE, 32'd0, 4'd0, '0);
    send_item(OP_DEFINE, 32'd0, 4'd9, '0);
    send_item(OP_DEFINE, 32'd0, 4'd15, '1);
    send_item(OP_GET, 32'd0, 4'd1, '0);
    send_item(OP_FIRST_DIRTY, 32'd0, 4'd1, '0);
    send_item(OP_DEFINE, 32'd0, 4'd1, '0);
    send_item(OP_DEFINE, 32'd5, 4'd1, '0);
    send_item(OP_GET, 32'd0, 4'd8, '0);
    send_item(OP_SET, 32'd0, 4'd8, '1);
    send_item(OP_GET, 32'd0, 4'd8, '0);
    send_item(OP_FIRST_DIRTY, NO_KEY, 4'd8, '1);
    send_item(OP_CLEAR_ONE, 32'd0, 4'd8, '0);
    send_item(OP_FIRST_DIRTY, 32'd0, 4'd0, '0);
    send_item(OP_SET, 32'd1, 4'd8, '1);
    send_item(OP_GET, NO_KEY - 1, 4'd8, '1);
    send_item(OP_CLEAR_ONE, 32'd7, 4'd8, '0);
    send_item(OP_SPARE_LO, '1, 4'd15, '1);
    send_item(OP_SPARE_HI, '0, 4'd0, '0);
    send_item(OP_SET, 32'd0, 4'd1, 64'h5A);
    send_item(OP_CLEAR_ALL, 32'd0, 4'd0, '0);
    drain();

    // full buffer: stale and reserved keys, then an eight-byte point
    set_buffer_limit(9'd256);
    send_item(OP_DEFINE, 32'd0, 4'd1, '0);
    send_item(OP_DEFINE, NO_KEY, 4'd8, '0);
    send_item(OP_DEFINE, 32'h10, 4'd8, '0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 56; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 56; end
        default: begin sender_idle_pct = 35; stall_pct = 35; end
      endcase
      case (phase)
        1: cfg_v = $urandom_range(1, 256);
        2: cfg_v = sb.next_off + $urandom_range(0, 12);
        3: cfg_v = (sb.next_off > 1) ? $urandom_range(1, sb.next_off) : 1;
        5: cfg_v = sb.next_off + $urandom_range(1, 8);
        default: cfg_v = 256;
      endcase
      if (cfg_v > 256) cfg_v = 256;
      if (cfg_v < 1) cfg_v = 1;
      set_buffer_limit(CFG_W'(cfg_v));
      if (phase == 0) hold_go = 1'b1;
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    sb.close_out();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/kdps_pkg.sv
rtl/kdps_ctrl.sv
rtl/kdps_dpath.sv
rtl/keyed_dirty_point_store_top.sv
tb/keyed_dirty_point_store_tb.sv
